[hdl/abg_pkg.sv]
package abg_pkg;

    localparam int FIELD_W  = 16;
    localparam int SEG_W    = 16;
    localparam int RANGE_W  = 4;
    localparam int GAP_W    = 17;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 17;
    localparam int IN_DATA_W  = 4 * FIELD_W;
    localparam int OUT_DATA_W = 6 * FIELD_W;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_GAP   = 1'b1;

    localparam logic [RANGE_W-1:0]     MAX_RANGE_RST = 4'd4;
    localparam logic signed [GAP_W-1:0] MAX_GAP_RST  = 17'sd2;

    localparam logic [SEG_W-1:0] SEG_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLAN,
        ST_WALK
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic shift;   // take the input word into the window
        logic start;   // first group of a start segment
        logic emit;    // load a result into the output register
        logic last;    // final result of this input word
        logic clear;   // line end, reset segment count
    } cmd_t;

endpackage

[hdl/abg_ctrl.sv]
module abg_ctrl #(
    parameter int MAX_GROUP = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 out_free,
    input  logic                                 eol,
    input  logic [abg_pkg::SEG_W-1:0]            seg_n,
    input  logic [$clog2(MAX_GROUP+1)-1:0]       range,
    input  logic [MAX_GROUP-1:0]                 gap_ok,
    output abg_pkg::cmd_t                        cmd,
    output logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] s_idx,
    output logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] j_idx
);
    import abg_pkg::*;

    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   s_reg, s_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   bot_reg, bot_next;

    logic               fits;
    logic               none;
    logic [IDX_W-1:0]   top;
    logic [IDX_W-1:0]   bottom;
    logic [IDX_W-1:0]   j_prev;
    logic               run_end;
    logic               final_res;

    // plan the start segments once the window and count have been updated
    always_comb begin
        fits   = SEG_W'(range) <= seg_n;
        none   = !eol && !fits;
        if (eol && !fits) begin
            top = IDX_W'(seg_n - 16'd1);
        end else begin
            top = IDX_W'(range - 1'b1);
        end
        bottom = eol ? '0 : IDX_W'(range - 1'b1);
    end

    // a start stops growing at the newest slot of its reach or at a wide gap
    always_comb begin
        j_prev    = j_reg - 1'b1;
        run_end   = (j_reg == '0) || !gap_ok[j_prev];
        final_res = run_end && (s_reg == bot_reg);
    end

    always_comb begin
        state_next = state_reg;
        s_next     = s_reg;
        j_next     = j_reg;
        bot_next   = bot_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                if (none) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_WALK;
                    s_next     = top;
                    j_next     = top;
                    bot_next   = bottom;
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    priority if (final_res) begin
                        state_next = ST_IDLE;
                    end else if (run_end) begin
                        s_next = s_reg - 1'b1;
                        j_next = s_reg - 1'b1;
                    end else begin
                        j_next = j_prev;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready  = 1'b1;
                cmd.shift = in_valid;
            end
            ST_PLAN: begin
            end
            ST_WALK: begin
                cmd.emit  = out_free;
                cmd.start = (j_reg == s_reg);
                cmd.last  = final_res;
                cmd.clear = out_free && final_res && eol;
            end
            default: begin
            end
        endcase
    end

    assign s_idx = s_reg;
    assign j_idx = j_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            s_reg     <= '0;
            j_reg     <= '0;
            bot_reg   <= '0;
        end else begin
            state_reg <= state_next;
            s_reg     <= s_next;
            j_reg     <= j_next;
            bot_reg   <= bot_next;
        end
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> out_free)
        else $error("result loaded while output register is occupied");

    a_j_in_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (j_reg <= s_reg) && (bot_reg <= s_reg))
        else $error("walk index outside the current start");

    a_plan_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_PLAN))
        else $error("accepted word not planned");

endmodule

[hdl/abg_datapath.sv]
module abg_datapath #(
    parameter int MAX_GROUP  = 8,
    parameter int COORD_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [abg_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [abg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [abg_pkg::IN_DATA_W-1:0]        in_data,
    input  logic                                 in_last,
    input  abg_pkg::cmd_t                        cmd,
    input  logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] s_idx,
    input  logic [((MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1)-1:0] j_idx,
    output logic                                 eol,
    output logic [abg_pkg::SEG_W-1:0]            seg_n,
    output logic [$clog2(MAX_GROUP+1)-1:0]       range,
    output logic [MAX_GROUP-1:0]                 gap_ok,
    output logic                                 out_free,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [abg_pkg::OUT_DATA_W-1:0]       out_data,
    output logic                                 out_last
);
    import abg_pkg::*;

    localparam int RW = $clog2(MAX_GROUP+1);
    localparam int GW = COORD_BITS + 1;

    logic [RANGE_W-1:0]      max_range_reg;
    logic signed [GAP_W-1:0] max_gap_reg;

    logic [COORD_BITS-1:0]   x0_reg [MAX_GROUP];
    logic [COORD_BITS-1:0]   y0_reg [MAX_GROUP];
    logic [COORD_BITS-1:0]   x1_reg [MAX_GROUP];
    logic [COORD_BITS-1:0]   y1_reg [MAX_GROUP];
    logic signed [GW-1:0]    gap_reg [MAX_GROUP];
    logic                    eol_reg;
    logic [SEG_W-1:0]        count_reg;

    logic [COORD_BITS-1:0]   ox0_reg, oy0_reg, ox1_reg, oy1_reg;
    logic [SEG_W-1:0]        first_reg, last_reg;
    logic                    olast_reg;
    logic                    ovalid_reg, ovalid_next;

    logic [COORD_BITS-1:0]   in_x0, in_y0, in_x1, in_y1;
    logic signed [GW-1:0]    gap_new;
    logic [COORD_BITS-1:0]   rd_x0, rd_y0, rd_x1, rd_y1;

    assign in_x0 = in_data[0*FIELD_W +: COORD_BITS];
    assign in_y0 = in_data[1*FIELD_W +: COORD_BITS];
    assign in_x1 = in_data[2*FIELD_W +: COORD_BITS];
    assign in_y1 = in_data[3*FIELD_W +: COORD_BITS];

    // gap from the box now in the front slot to the incoming one
    assign gap_new = $signed({1'b0, in_x0}) - $signed({1'b0, x1_reg[0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_range_reg <= MAX_RANGE_RST;
            max_gap_reg   <= MAX_GAP_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_MAX_RANGE: max_range_reg <= cfg_wdata[RANGE_W-1:0];
                REG_MAX_GAP:   max_gap_reg   <= $signed(cfg_wdata[GAP_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // clamp range into 1..MAX_GROUP
    always_comb begin
        priority if (max_range_reg == '0) begin
            range = RW'(1);
        end else if (max_range_reg > RANGE_W'(MAX_GROUP)) begin
            range = RW'(MAX_GROUP);
        end else begin
            range = RW'(max_range_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_GROUP; i++) begin
            gap_ok[i] = GAP_W'(gap_reg[i]) <= max_gap_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift) begin
            for (int i = MAX_GROUP - 1; i > 0; i--) begin
                x0_reg[i]  <= x0_reg[i-1];
                y0_reg[i]  <= y0_reg[i-1];
                x1_reg[i]  <= x1_reg[i-1];
                y1_reg[i]  <= y1_reg[i-1];
                gap_reg[i] <= gap_reg[i-1];
            end
            x0_reg[0]  <= in_x0;
            y0_reg[0]  <= in_y0;
            x1_reg[0]  <= in_x1;
            y1_reg[0]  <= in_y1;
            gap_reg[0] <= gap_new;
            eol_reg    <= in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear) begin
            count_reg <= '0;
        end else if (cmd.shift && count_reg != SEG_MAX) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    assign eol   = eol_reg;
    assign seg_n = count_reg;

    assign rd_x0 = x0_reg[j_idx];
    assign rd_y0 = y0_reg[j_idx];
    assign rd_x1 = x1_reg[j_idx];
    assign rd_y1 = y1_reg[j_idx];

    // output register also holds the running union box
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            if (cmd.start) begin
                ox0_reg <= rd_x0;
                oy0_reg <= rd_y0;
                ox1_reg <= rd_x1;
                oy1_reg <= rd_y1;
            end else begin
                ox0_reg <= (rd_x0 < ox0_reg) ? rd_x0 : ox0_reg;
                oy0_reg <= (rd_y0 < oy0_reg) ? rd_y0 : oy0_reg;
                ox1_reg <= (rd_x1 > ox1_reg) ? rd_x1 : ox1_reg;
                oy1_reg <= (rd_y1 > oy1_reg) ? rd_y1 : oy1_reg;
            end
            first_reg <= count_reg - SEG_W'(s_idx);
            last_reg  <= count_reg - SEG_W'(j_idx);
            olast_reg <= cmd.last;
        end
    end

    always_comb begin
        if (cmd.emit) begin
            ovalid_next = 1'b1;
        end else if (out_ready) begin
            ovalid_next = 1'b0;
        end else begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_free  = !ovalid_reg || out_ready;
    assign out_valid = ovalid_reg;
    assign out_last  = olast_reg;
    assign out_data  = {last_reg, first_reg,
                        FIELD_W'(oy1_reg), FIELD_W'(ox1_reg),
                        FIELD_W'(oy0_reg), FIELD_W'(ox0_reg)};

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.shift |=> (count_reg != '0))
        else $error("segment count zero after a box was taken");

    a_clear_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (count_reg == '0))
        else $error("segment count not cleared at line end");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> (last_reg >= first_reg) || (count_reg == '0))
        else $error("group indices out of order");

endmodule

[hdl/adjacent_box_grouper_top.sv]
// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  tdata: box_x0,y0,x1,y1; tlast: end_of_line
// m_        out  m_tvalid/m_tready  tdata: group box, first/last segment; tlast: last_of_run
// cfg_      in   cfg_we             cfg_addr 0: max_range, 1: max_gap
//
// an input word is taken through window shift and start planning and then, unless it
// releases no group, the walk; the walk reads one window slot per cycle while the output
// register is free, one group per slot, up to 36 groups at a line end with max_range 8
// reset is synchronous, active low; it clears control, segment count and config,
// the box window is not cleared and is only read where written in the current line
// m_tready low holds the walk while a result waits in the output register; s_tready is high only between words
module adjacent_box_grouper_top #(
    parameter int MAX_GROUP  = 8,
    parameter int COORD_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [abg_pkg::IN_DATA_W-1:0]     s_tdata,   // box_x0, box_y0, box_x1, box_y1
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [abg_pkg::OUT_DATA_W-1:0]    m_tdata,   // group_x0, group_y0, group_x1,
                                                         // group_y1, first_segment, last_segment
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [abg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [abg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import abg_pkg::*;

    localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int RW    = $clog2(MAX_GROUP+1);

    cmd_t               cmd;
    logic [IDX_W-1:0]   s_idx;
    logic [IDX_W-1:0]   j_idx;
    logic               eol;
    logic [SEG_W-1:0]   seg_n;
    logic [RW-1:0]      range;
    logic [MAX_GROUP-1:0] gap_ok;
    logic               out_free;

    abg_ctrl #(
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .eol      (eol),
        .seg_n    (seg_n),
        .range    (range),
        .gap_ok   (gap_ok),
        .cmd      (cmd),
        .s_idx    (s_idx),
        .j_idx    (j_idx)
    );

    abg_datapath #(
        .MAX_GROUP  (MAX_GROUP),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .s_idx     (s_idx),
        .j_idx     (j_idx),
        .eol       (eol),
        .seg_n     (seg_n),
        .range     (range),
        .gap_ok    (gap_ok),
        .out_free  (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
    import abg_pkg::*;

    localparam int WIN_DEPTH = 8;
    localparam int SETTLE    = 48;     // worst word: window shift, planning and 36 groups, plus margin
    localparam int QUIET_MAX = 4000;
    localparam int PRINT_MAX = 30;

    typedef struct packed {
        logic [15:0] y1;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] x0;
    } box_t;

    // same layout as {m_tlast, m_tdata}
    typedef struct packed {
        logic        end_run;
        logic [15:0] last_seg;
        logic [15:0] first_seg;
        logic [15:0] y1;
        logic [15:0] x1;
        logic [15:0] y0;
        logic [15:0] x0;
    } group_t;

    typedef enum logic {
        ROW_BOX,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        box_t                  b;
        logic                  eol;
        logic                  typed;
        group_t                want;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;    // box_x0, box_y0, box_x1, box_y1
    logic                  s_tlast;    // end_of_line
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;    // group_x0, group_y0, group_x1, group_y1,
                                       // first_segment, last_segment
    logic                  m_tlast;    // last_of_run
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // predictor state
    box_t               window_boxes [WIN_DEPTH];
    logic [SEG_W-1:0]   seg_cnt;
    logic [RANGE_W-1:0] cur_range;
    logic signed [GAP_W-1:0] cur_gap;
    group_t             pending_groups [$];

    int mismatches;
    int quiet_cycles;
    int tx_idle_pct;
    int rx_stall_pct;

    adjacent_box_grouper_top #(
        .MAX_GROUP  (WIN_DEPTH),
        .COORD_BITS (16)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int clamp16(input int v);
        if (v < 0) begin
            return 0;
        end
        if (v > 65535) begin
            return 65535;
        end
        return v;
    endfunction

    function automatic row_t box_row(input int x0, input int y0, input int x1, input int y1,
                                     input logic eol);
        row_t r;
        r.kind  = ROW_BOX;
        r.b     = {y1[15:0], x1[15:0], y0[15:0], x0[15:0]};
        r.eol   = eol;
        r.typed = 1'b0;
        r.want  = '0;
        r.addr  = '0;
        r.wdata = '0;
        return r;
    endfunction

    // one-box line: the only group is the box itself, segment 1
    function automatic row_t typed_row(input int x0, input int y0, input int x1, input int y1);
        row_t r;
        r       = box_row(x0, y0, x1, y1, 1'b1);
        r.typed = 1'b1;
        r.want  = {1'b1, 16'd1, 16'd1, r.b};
        return r;
    endfunction

    function automatic row_t reg_row(input logic [CFG_ADDR_W-1:0] addr,
                                     input logic [CFG_DATA_W-1:0] data);
        row_t r;
        r       = box_row(0, 0, 0, 0, 1'b0);
        r.kind  = ROW_REG;
        r.addr  = addr;
        r.wdata = data;
        return r;
    endfunction

    function automatic string group_text(input group_t g);
        return $sformatf("%0d,%0d,%0d,%0d seg %0d..%0d last %0b",
                         g.x0, g.y0, g.x1, g.y1, g.first_seg, g.last_seg, g.end_run);
    endfunction

    // shift the box in and work out every group this word releases
    task automatic predict_groups(input box_t b, input logic eol, input bit keep);
        int     i, r, n, top, bottom, s, maxlen, len, j, lim, nx, px;
        box_t   u;
        group_t g;
        group_t found [$];
        for (i = WIN_DEPTH - 1; i > 0; i--) begin
            window_boxes[i] = window_boxes[i-1];
        end
        window_boxes[0] = b;
        if (seg_cnt != SEG_MAX) begin
            seg_cnt = seg_cnt + 1'b1;
        end
        n = seg_cnt;
        r = cur_range;
        if (r < 1) begin
            r = 1;
        end
        if (r > WIN_DEPTH) begin
            r = WIN_DEPTH;
        end
        if (eol) begin
            top    = (r <= n) ? r - 1 : n - 1;
            bottom = 0;
        end else begin
            top    = (n < r) ? -1 : r - 1;
            bottom = r - 1;
        end
        lim = cur_gap;
        for (s = top; s >= bottom; s--) begin
            maxlen      = (s + 1 < r) ? s + 1 : r;
            u           = window_boxes[s];
            g.end_run   = 1'b0;
            g.first_seg = SEG_W'(n - s);
            g.last_seg  = SEG_W'(n - s);
            g.x0        = u.x0;
            g.y0        = u.y0;
            g.x1        = u.x1;
            g.y1        = u.y1;
            found.push_back(g);
            for (len = 2; len <= maxlen; len++) begin
                j  = s - len + 1;
                nx = window_boxes[j].x0;
                px = window_boxes[j+1].x1;
                if (nx - px > lim) begin
                    break;
                end
                if (window_boxes[j].x0 < g.x0) g.x0 = window_boxes[j].x0;
                if (window_boxes[j].y0 < g.y0) g.y0 = window_boxes[j].y0;
                if (window_boxes[j].x1 > g.x1) g.x1 = window_boxes[j].x1;
                if (window_boxes[j].y1 > g.y1) g.y1 = window_boxes[j].y1;
                g.last_seg = SEG_W'(n - j);
                found.push_back(g);
            end
        end
        if (found.size() > 0) begin
            found[found.size()-1].end_run = 1'b1;
        end
        if (eol) begin
            seg_cnt = '0;
        end
        if (keep) begin
            foreach (found[i]) begin
                pending_groups.push_back(found[i]);
            end
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_box(input box_t b, input logic eol, input logic typed, input group_t want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_groups(b, eol, !typed);
        if (typed) begin
            pending_groups.push_back(want);
        end
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        s_tvalid <= 1'b0;
        while (pending_groups.size() != 0) begin
            @(negedge aclk);
        end
        // a word with no groups may still be in the datapath
        repeat (SETTLE) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (addr == REG_MAX_RANGE) begin
            cur_range = data[RANGE_W-1:0];
        end else begin
            cur_gap = data[GAP_W-1:0];
        end
    endtask

    // lines of left-to-right boxes with gaps near the limit, some noise words mixed in
    task automatic run_phase(input int tx_pct, input int rx_pct, input logic [3:0] range_val,
                             input logic [GAP_W-1:0] gap_val, input int n_items);
        int   sent, len, k, lim, g, px1, x0v, x1v, y0v, y1v, tmp;
        box_t b;
        write_reg(REG_MAX_RANGE, {13'd0, range_val});
        write_reg(REG_MAX_GAP, gap_val);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            px1 = $urandom_range(0, 60000);
            lim = cur_gap;
            if (lim < -20) lim = -20;
            if (lim > 300) lim = 300;
            for (k = 0; k < len; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    b = {$urandom, $urandom};
                end else begin
                    g   = $urandom_range(0, 6);
                    g   = g + lim - 3;
                    x0v = clamp16(px1 + g);
                    tmp = $urandom_range(0, 300);
                    x1v = clamp16(x0v + tmp);
                    y0v = $urandom_range(0, 65535);
                    tmp = $urandom_range(0, 400);
                    y1v = clamp16(y0v + tmp);
                    if ($urandom_range(0, 9) == 0) begin
                        tmp = x0v;
                        x0v = x1v;
                        x1v = tmp;
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        tmp = y0v;
                        y0v = y1v;
                        y1v = tmp;
                    end
                    b = {y1v[15:0], x1v[15:0], y0v[15:0], x0v[15:0]};
                end
                px1 = b.x1;
                send_box(b, k == len - 1, 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input group_t got, input group_t want);
        if (mismatches < PRINT_MAX) begin
            $display("mismatch: %s got %s want %s", what, group_text(got), group_text(want));
        end
        mismatches++;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        group_t got;
        group_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata};
            if (pending_groups.size() == 0) begin
                report_mismatch("word with nothing pending", got, got);
            end else begin
                want = pending_groups.pop_front();
                if (got !== want) begin
                    report_mismatch("group", got, want);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        row_t plan [$];
        box_t b;
        int   i;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        mismatches   = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        cur_range    = MAX_RANGE_RST;
        cur_gap      = MAX_GAP_RST;
        seg_cnt      = '0;
        foreach (window_boxes[i]) begin
            window_boxes[i] = '0;
        end

        // single-box lines right after reset
        plan.push_back(typed_row(10, 20, 30, 40));
        plan.push_back(typed_row(0, 0, 0, 0));
        plan.push_back(typed_row(65535, 65535, 65535, 65535));
        // short line, gap break after the second box
        plan.push_back(box_row(0, 5, 10, 15, 1'b0));
        plan.push_back(box_row(11, 3, 20, 30, 1'b0));
        plan.push_back(box_row(30, 0, 40, 10, 1'b1));
        // full line with inverted boxes and a break
        plan.push_back(box_row(100, 50, 120, 80, 1'b0));
        plan.push_back(box_row(122, 40, 110, 90, 1'b0));
        plan.push_back(box_row(111, 60, 150, 55, 1'b0));
        plan.push_back(box_row(152, 10, 160, 20, 1'b0));
        plan.push_back(box_row(170, 30, 180, 40, 1'b0));
        plan.push_back(box_row(181, 0, 200, 100, 1'b1));
        // range zero behaves as one
        plan.push_back(reg_row(REG_MAX_RANGE, 17'd0));
        plan.push_back(box_row(5, 5, 6, 6, 1'b0));
        plan.push_back(box_row(7, 7, 8, 8, 1'b1));
        // range above the window clamps, widest gap: full flush of 36 groups
        plan.push_back(reg_row(REG_MAX_RANGE, 17'd15));
        plan.push_back(reg_row(REG_MAX_GAP, 17'h0FFFF));
        plan.push_back(box_row(0, 100, 65535, 200, 1'b0));
        plan.push_back(box_row(0, 50, 10, 300, 1'b0));
        plan.push_back(box_row(9000, 0, 9100, 65535, 1'b0));
        plan.push_back(box_row(65535, 7, 65535, 8, 1'b0));
        plan.push_back(box_row(20, 20, 30, 30, 1'b0));
        plan.push_back(box_row(40, 40, 50, 50, 1'b0));
        plan.push_back(box_row(60, 1, 70, 2, 1'b0));
        plan.push_back(box_row(80, 3, 90, 4, 1'b1));
        // most negative gap: only an exact -65535 step still merges
        plan.push_back(reg_row(REG_MAX_GAP, 17'h10001));
        plan.push_back(box_row(10, 10, 65535, 20, 1'b0));
        plan.push_back(box_row(0, 0, 5, 65535, 1'b0));
        // range lowered in mid-line
        plan.push_back(reg_row(REG_MAX_RANGE, 17'd2));
        plan.push_back(box_row(30, 30, 40, 40, 1'b0));
        plan.push_back(box_row(50, 50, 60, 60, 1'b1));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                write_reg(plan[i].addr, plan[i].wdata);
            end else begin
                send_box(plan[i].b, plan[i].eol, plan[i].typed, plan[i].want);
            end
        end

        run_phase(0, 0, 4'd8, 17'h0FFFF, 48);
        run_phase(84, 0, 4'd3, 17'h10001, 48);
        run_phase(0, 84, 4'd1, 17'd0, 48);
        run_phase(13, 13, 4'd15, 17'd40, 48);
        run_phase(0, 0, 4'($urandom_range(0, 15)), GAP_W'($urandom_range(0, 40) - 20), 48);

        // short line flushed at the widest range
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_reg(REG_MAX_RANGE, 17'd8);
        for (i = 0; i < 4; i++) begin
            b = {$urandom, $urandom};
            send_box(b, i == 3, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_groups.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
